// File: hdl/rmlc_pkg.sv
// Shared constants, types and state codes for the running median load-cell filter.
package rmlc_pkg;

  localparam int WINDOW     = 5;
  localparam int AGE_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FILL_W     = $clog2(WINDOW + 1);
  localparam int CNT_W      = 24;
  localparam int WEIGHT_W   = 32;
  localparam int ZO_W       = 32;
  localparam int GAIN_W     = 40;
  localparam int GAIN_HALF  = GAIN_W / 2;
  localparam int DIFF_W     = 34;
  localparam int PROD_W     = DIFF_W + GAIN_HALF;
  localparam int ACC_W      = DIFF_W + GAIN_W;
  localparam int FRAC_DROP  = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = GAIN_W;

  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN        = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEL,
    ST_INS,
    ST_MED,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_RND
  } state_t;

  typedef struct packed {
    logic signed [CNT_W-1:0] val;
    logic [AGE_W-1:0]        age;
  } cell_t;

  typedef struct packed {
    logic del;
    logic ins;
  } chain_ctl_t;

  typedef struct packed {
    logic load;
    logic mul_lo;
    logic mul_hi;
  } scale_ctl_t;

endpackage

// File: hdl/rmlc_if.sv
// Handshake channels for sample beats in and weight beats out.
interface rmlc_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [rmlc_pkg::CNT_W-1:0] raw_count;

  modport source (output valid, output raw_count, input ready);
  modport sink   (input valid, input raw_count, output ready);
endinterface

interface rmlc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [rmlc_pkg::WEIGHT_W-1:0] weight;

  modport source (output valid, output weight, input ready);
  modport sink   (input valid, input weight, output ready);
endinterface

// File: hdl/rmlc_cell.sv
// One cell of the sorted window: holds a sample and its age, shifts with its neighbours.
module rmlc_cell (
  input  logic                          clk,
  input  rmlc_pkg::chain_ctl_t          ctl_i,
  input  logic                          valid_i,
  input  logic signed [rmlc_pkg::CNT_W-1:0] x_i,
  input  rmlc_pkg::cell_t               left_i,
  input  logic                          left_gt_i,
  input  rmlc_pkg::cell_t               right_i,
  input  logic                          seen_prev_i,
  output rmlc_pkg::cell_t               cell_o,
  output logic                          gt_o,
  output logic                          seen_o
);

  rmlc_pkg::cell_t cell_r;
  rmlc_pkg::cell_t cell_nxt;
  logic            match;

  // oldest sample in a full window carries the top age
  assign match  = ctl_i.del && valid_i &&
                  (cell_r.age == rmlc_pkg::AGE_W'(rmlc_pkg::WINDOW - 1));
  assign seen_o = seen_prev_i || match;
  assign gt_o   = valid_i && (cell_r.val > x_i);
  assign cell_o = cell_r;

  always_comb begin
    cell_nxt = cell_r;
    if (ctl_i.del) begin
      // close the gap left by the dropped sample
      if (seen_o) begin
        cell_nxt = right_i;
      end
    end else if (ctl_i.ins) begin
      if (left_gt_i) begin
        cell_nxt.val = left_i.val;
        cell_nxt.age = left_i.age + rmlc_pkg::AGE_W'(1);
      end else if (gt_o || !valid_i) begin
        cell_nxt.val = x_i;
        cell_nxt.age = '0;
      end else begin
        cell_nxt.age = cell_r.age + rmlc_pkg::AGE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

endmodule

// File: hdl/rmlc_chain.sv
// Row of sorted cells with the fill count and the median tap.
module rmlc_chain (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rmlc_pkg::chain_ctl_t              ctl_i,
  input  logic signed [rmlc_pkg::CNT_W-1:0] x_i,
  output logic signed [rmlc_pkg::CNT_W-1:0] median_o
);

  logic [rmlc_pkg::FILL_W-1:0] fill_r;
  logic [rmlc_pkg::FILL_W-1:0] fill_nxt;
  logic                        full;
  rmlc_pkg::chain_ctl_t        cell_ctl;
  rmlc_pkg::cell_t             cells [rmlc_pkg::WINDOW];
  logic                        gt    [rmlc_pkg::WINDOW];
  logic                        seen  [rmlc_pkg::WINDOW];
  logic [rmlc_pkg::AGE_W-1:0]  med_idx;

  assign full         = (fill_r == rmlc_pkg::FILL_W'(rmlc_pkg::WINDOW));
  assign cell_ctl.del = ctl_i.del && full;
  assign cell_ctl.ins = ctl_i.ins;

  for (genvar i = 0; i < rmlc_pkg::WINDOW; i++) begin : g_cell
    rmlc_pkg::cell_t left_c;
    rmlc_pkg::cell_t right_c;
    logic            left_gt;
    logic            seen_prev;
    logic            valid;

    assign valid = (rmlc_pkg::FILL_W'(i) < fill_r);

    if (i == 0) begin : g_first
      assign left_c    = cells[i];
      assign left_gt   = 1'b0;
      assign seen_prev = 1'b0;
    end else begin : g_inner
      assign left_c    = cells[i-1];
      assign left_gt   = gt[i-1];
      assign seen_prev = seen[i-1];
    end

    if (i == rmlc_pkg::WINDOW - 1) begin : g_last
      assign right_c = cells[i];
    end else begin : g_body
      assign right_c = cells[i+1];
    end

    rmlc_cell u_cell (
      .clk         (clk),
      .ctl_i       (cell_ctl),
      .valid_i     (valid),
      .x_i         (x_i),
      .left_i      (left_c),
      .left_gt_i   (left_gt),
      .right_i     (right_c),
      .seen_prev_i (seen_prev),
      .cell_o      (cells[i]),
      .gt_o        (gt[i]),
      .seen_o      (seen[i])
    );
  end

  always_comb begin
    fill_nxt = fill_r;
    if (cell_ctl.del) begin
      fill_nxt = fill_r - rmlc_pkg::FILL_W'(1);
    end else if (cell_ctl.ins) begin
      fill_nxt = fill_r + rmlc_pkg::FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // upper median: element fill/2 of the sorted row
  assign med_idx  = rmlc_pkg::AGE_W'(fill_r >> 1);
  assign median_o = cells[med_idx].val;

endmodule

// File: hdl/rmlc_scale.sv
// Tare subtract, gain multiply in two halves on one multiplier, round and saturate.
module rmlc_scale (
  input  logic                                 clk,
  input  rmlc_pkg::scale_ctl_t                 ctl_i,
  input  logic signed [rmlc_pkg::CNT_W-1:0]    median_i,
  input  logic signed [rmlc_pkg::ZO_W-1:0]     zero_offset_i,
  input  logic [rmlc_pkg::GAIN_W-1:0]          gain_i,
  output logic signed [rmlc_pkg::WEIGHT_W-1:0] weight_o
);

  localparam int Q_W = rmlc_pkg::ACC_W - rmlc_pkg::FRAC_DROP;
  localparam logic [rmlc_pkg::ACC_W-1:0] ROUND_BIAS =
    rmlc_pkg::ACC_W'(1) << (rmlc_pkg::FRAC_DROP - 1);

  logic [rmlc_pkg::DIFF_W-1:0]    diff;
  logic [rmlc_pkg::DIFF_W-1:0]    mag_r;
  logic                           neg_r;
  logic [rmlc_pkg::GAIN_HALF-1:0] gain_part;
  logic [rmlc_pkg::PROD_W-1:0]    prod;
  logic [rmlc_pkg::ACC_W-1:0]     acc_r;
  logic [rmlc_pkg::ACC_W-1:0]     acc_nxt;
  logic [rmlc_pkg::ACC_W-1:0]     rounded;
  logic [Q_W-1:0]                 q;

  // median widened to Q24.8 minus the tare, exact in DIFF_W bits
  assign diff = {{2{median_i[rmlc_pkg::CNT_W-1]}}, median_i, 8'b0}
              - {{2{zero_offset_i[rmlc_pkg::ZO_W-1]}}, zero_offset_i};

  always_ff @(posedge clk) begin
    if (ctl_i.load) begin
      neg_r <= diff[rmlc_pkg::DIFF_W-1];
      mag_r <= diff[rmlc_pkg::DIFF_W-1] ? (rmlc_pkg::DIFF_W'(0) - diff) : diff;
    end
  end

  assign gain_part = ctl_i.mul_hi ? gain_i[rmlc_pkg::GAIN_W-1:rmlc_pkg::GAIN_HALF]
                                  : gain_i[rmlc_pkg::GAIN_HALF-1:0];
  assign prod      = rmlc_pkg::PROD_W'(mag_r) * rmlc_pkg::PROD_W'(gain_part);

  always_comb begin
    acc_nxt = acc_r;
    if (ctl_i.mul_lo) begin
      acc_nxt = rmlc_pkg::ACC_W'(prod);
    end else if (ctl_i.mul_hi) begin
      acc_nxt = acc_r + {prod, {rmlc_pkg::GAIN_HALF{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // round to nearest on the magnitude, ties away from zero
  assign rounded = acc_r + ROUND_BIAS;
  assign q       = rounded[rmlc_pkg::ACC_W-1:rmlc_pkg::FRAC_DROP];

  always_comb begin
    if (neg_r) begin
      if (q[Q_W-1:rmlc_pkg::WEIGHT_W-1] != '0) begin
        weight_o = {1'b1, {(rmlc_pkg::WEIGHT_W-1){1'b0}}};
      end else begin
        weight_o = rmlc_pkg::WEIGHT_W'(0) - q[rmlc_pkg::WEIGHT_W-1:0];
      end
    end else begin
      if (q[Q_W-1:rmlc_pkg::WEIGHT_W-1] != '0) begin
        weight_o = {1'b0, {(rmlc_pkg::WEIGHT_W-1){1'b1}}};
      end else begin
        weight_o = q[rmlc_pkg::WEIGHT_W-1:0];
      end
    end
  end

endmodule

// File: hdl/running_median_load_cell.sv
// Top level: running median of load-cell counts scaled to saturated Q16.16 kilograms.
//
//   channel   direction  handshake          payload
//   in_ch     in         valid/ready        raw_count  s24 counts
//   out_ch    out        valid/ready        weight     s32 Q16.16 kg
//   cfg_*     in         cfg_we, no ready   0 zero_offset s32 Q24.8, 1 gain u40 Q8.32
//
// An item goes from its input beat to its registered result in these steps, in order:
// take the beat, drop the oldest sample from the sorted cell row once it is full,
// insert the new one, take the median tap and tare, form the gain product in two
// halves on the shared multiplier and round. One item is in work at a time.
// A result waiting in the output register does not block the next input beat; the
// rounding step holds until the output register is free.
// Synchronous reset empties the window and loads zero_offset 0 and gain 1.0.
module running_median_load_cell (
  input  logic                                 clk,
  input  logic                                 rst_n,
  rmlc_in_if.sink                              in_ch,
  rmlc_out_if.source                           out_ch,
  input  logic                                 cfg_we,
  input  logic [rmlc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rmlc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  rmlc_pkg::state_t                     state_r;
  rmlc_pkg::state_t                     state_nxt;
  rmlc_pkg::chain_ctl_t                 chain_ctl;
  rmlc_pkg::scale_ctl_t                 scale_ctl;
  logic                                 out_load;
  logic                                 out_valid_r;
  logic signed [rmlc_pkg::WEIGHT_W-1:0] weight_r;
  logic signed [rmlc_pkg::WEIGHT_W-1:0] weight;
  logic signed [rmlc_pkg::CNT_W-1:0]    x_r;
  logic signed [rmlc_pkg::CNT_W-1:0]    median;
  logic signed [rmlc_pkg::ZO_W-1:0]     zero_offset_r;
  logic [rmlc_pkg::GAIN_W-1:0]          gain_r;
  logic                                 in_beat;

  assign in_beat = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_offset_r <= '0;
      gain_r        <= rmlc_pkg::GAIN_W'(64'h1_0000_0000);
    end else if (cfg_we) begin
      unique case (cfg_index)
        rmlc_pkg::CFG_ZERO_OFFSET: zero_offset_r <= cfg_wdata[rmlc_pkg::ZO_W-1:0];
        rmlc_pkg::CFG_GAIN:        gain_r        <= cfg_wdata[rmlc_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      x_r <= in_ch.raw_count;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rmlc_pkg::ST_IDLE:   if (in_beat) state_nxt = rmlc_pkg::ST_DEL;
      rmlc_pkg::ST_DEL:    state_nxt = rmlc_pkg::ST_INS;
      rmlc_pkg::ST_INS:    state_nxt = rmlc_pkg::ST_MED;
      rmlc_pkg::ST_MED:    state_nxt = rmlc_pkg::ST_MUL_LO;
      rmlc_pkg::ST_MUL_LO: state_nxt = rmlc_pkg::ST_MUL_HI;
      rmlc_pkg::ST_MUL_HI: state_nxt = rmlc_pkg::ST_RND;
      rmlc_pkg::ST_RND:    if (!out_valid_r || out_ch.ready) state_nxt = rmlc_pkg::ST_IDLE;
      default:             state_nxt = rmlc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready      = 1'b0;
    chain_ctl.del    = 1'b0;
    chain_ctl.ins    = 1'b0;
    scale_ctl.load   = 1'b0;
    scale_ctl.mul_lo = 1'b0;
    scale_ctl.mul_hi = 1'b0;
    out_load         = 1'b0;
    unique case (state_r)
      rmlc_pkg::ST_IDLE:   in_ch.ready      = 1'b1;
      rmlc_pkg::ST_DEL:    chain_ctl.del    = 1'b1;
      rmlc_pkg::ST_INS:    chain_ctl.ins    = 1'b1;
      rmlc_pkg::ST_MED:    scale_ctl.load   = 1'b1;
      rmlc_pkg::ST_MUL_LO: scale_ctl.mul_lo = 1'b1;
      rmlc_pkg::ST_MUL_HI: scale_ctl.mul_hi = 1'b1;
      rmlc_pkg::ST_RND:    out_load         = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rmlc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  rmlc_chain u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_i    (chain_ctl),
    .x_i      (x_r),
    .median_o (median)
  );

  rmlc_scale u_scale (
    .clk           (clk),
    .ctl_i         (scale_ctl),
    .median_i      (median),
    .zero_offset_i (zero_offset_r),
    .gain_i        (gain_r),
    .weight_o      (weight)
  );

  // output beat register: load a new weight, or drop the old one once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      weight_r <= weight;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.weight = weight_r;

endmodule
